[sv/spq_pkg.sv]
package spq_pkg;

  localparam int unsigned NUM_LVL = 3;
  localparam int unsigned LVL_W   = 2;
  localparam int unsigned URG_W   = 2;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned AGE_W   = 8;
  localparam int unsigned OCC_W   = 7;
  localparam int unsigned STS_W   = 2;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [STS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the accepted beat and start the head read
    logic exec;     // perform the operation and load the result register
  } spq_cmd_t;

endpackage

[sv/stable_priority_queue.sv]
// The accept state captures the input beat and the execute state then loads the result register,
// waiting while the output register still holds an unaccepted result.
// The two-state controller (accept, execute) takes no new beat until the previous one has executed.
// A dequeue reads the head entry in the accept cycle; the execute cycle writes or retires.
// Reset (rst_ni low, asynchronous) empties the queue and clears the handshake state.
// Entry storage is not cleared; only entries written since reset are ever read.
module stable_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       op_i,
  input  logic [spq_pkg::URG_W-1:0]  urgency_i,
  input  logic [spq_pkg::TAG_W-1:0]  record_tag_i,
  input  logic [spq_pkg::AGE_W-1:0]  patient_age_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [spq_pkg::STS_W-1:0]  status_o,
  output logic [spq_pkg::URG_W-1:0]  out_urgency_o,
  output logic [spq_pkg::TAG_W-1:0]  out_tag_o,
  output logic [spq_pkg::AGE_W-1:0]  out_age_o,
  output logic                       now_empty_o,
  output logic [spq_pkg::OCC_W-1:0]  occupancy_now_o
);
  import spq_pkg::*;

  // The queue is kept as three ring buffers, one per level, which share
  // one occupancy limit; urgencies zero and one map to the same level.
  // Entries of equal urgency therefore leave in arrival order, and a dequeue
  // always serves the most urgent non-empty level. The level is implied by
  // the buffer, so only tag and age are stored.

  spq_cmd_t cmd;

  // The controller accepts a beat whenever it is idle, even while a previous
  // result beat still waits in the output register; the execute step then
  // waits until that register is free, so no result is ever overwritten.
  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // The datapath holds the storage, the per-level pointers and counts, and
  // the result register whose fields drive the output ports directly.
  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .op_i            (op_i),
    .urgency_i       (urgency_i),
    .record_tag_i    (record_tag_i),
    .patient_age_i   (patient_age_i),
    .status_o        (status_o),
    .out_urgency_o   (out_urgency_o),
    .out_tag_o       (out_tag_o),
    .out_age_o       (out_age_o),
    .now_empty_o     (now_empty_o),
    .occupancy_now_o (occupancy_now_o)
  );

endmodule

[sv/spq_ctrl.sv]
module spq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spq_pkg::spq_cmd_t cmd_o
);
  import spq_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.exec    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.exec = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[sv/spq_datapath.sv]
module spq_datapath #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  spq_pkg::spq_cmd_t          cmd_i,
  input  logic                       op_i,
  input  logic [spq_pkg::URG_W-1:0]  urgency_i,
  input  logic [spq_pkg::TAG_W-1:0]  record_tag_i,
  input  logic [spq_pkg::AGE_W-1:0]  patient_age_i,
  output logic [spq_pkg::STS_W-1:0]  status_o,
  output logic [spq_pkg::URG_W-1:0]  out_urgency_o,
  output logic [spq_pkg::TAG_W-1:0]  out_tag_o,
  output logic [spq_pkg::AGE_W-1:0]  out_age_o,
  output logic                       now_empty_o,
  output logic [spq_pkg::OCC_W-1:0]  occupancy_now_o
);
  import spq_pkg::*;

  localparam int unsigned AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned DW    = TAG_W + AGE_W;
  localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + AW'(1);
  endfunction

  // One ring buffer per urgency level; each may grow to the whole capacity.
  logic [DW-1:0]    mem_q [NUM_LVL][QUEUE_DEPTH];
  logic [DW-1:0]    rd_q;
  logic [AW-1:0]    head_q [NUM_LVL];
  logic [AW-1:0]    tail_q [NUM_LVL];
  logic [CW-1:0]    lcnt_q [NUM_LVL];
  logic [CW-1:0]    total_q, total_d;

  logic             op_q;
  logic [LVL_W-1:0] lvl_q, sel_q;
  logic [TAG_W-1:0] tag_q;
  logic [AGE_W-1:0] age_q;

  logic [LVL_W-1:0] in_lvl, sel_lvl;
  logic             is_empty, is_full, do_enq, do_deq;
  logic [CW+OCC_W-1:0] occ_wide;

  // Urgency zero is treated as the most urgent level.
  always_comb begin
    unique case (urgency_i) inside
      2'd0, 2'd1: in_lvl = LVL_W'(0);
      2'd2:       in_lvl = LVL_W'(1);
      default:    in_lvl = LVL_W'(2);
    endcase
  end

  always_comb begin
    if (lcnt_q[0] != '0) begin
      sel_lvl = LVL_W'(0);
    end else if (lcnt_q[1] != '0) begin
      sel_lvl = LVL_W'(1);
    end else begin
      sel_lvl = LVL_W'(2);
    end
  end

  assign is_empty = (total_q == '0);
  assign is_full  = (total_q == CNT_FULL);
  assign do_enq   = cmd_i.exec && (op_q == OP_ENQ) && !is_full;
  assign do_deq   = cmd_i.exec && (op_q == OP_DEQ) && !is_empty;

  always_comb begin
    total_d = total_q;
    if (do_enq) total_d = total_q + CW'(1);
    if (do_deq) total_d = total_q - CW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_i;
      lvl_q <= in_lvl;
      sel_q <= sel_lvl;
      tag_q <= record_tag_i;
      age_q <= patient_age_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_enq) begin
      mem_q[lvl_q][tail_q[lvl_q]] <= {tag_q, age_q};
    end
    if (cmd_i.capture) begin
      rd_q <= mem_q[sel_lvl][head_q[sel_lvl]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      for (int i = 0; i < NUM_LVL; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        lcnt_q[i] <= '0;
      end
    end else begin
      total_q <= total_d;
      if (do_enq) begin
        tail_q[lvl_q] <= ptr_inc(tail_q[lvl_q]);
        lcnt_q[lvl_q] <= lcnt_q[lvl_q] + CW'(1);
      end
      if (do_deq) begin
        head_q[sel_q] <= ptr_inc(head_q[sel_q]);
        lcnt_q[sel_q] <= lcnt_q[sel_q] - CW'(1);
      end
    end
  end

  assign occ_wide = {{OCC_W{1'b0}}, total_d};

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      now_empty_o     <= (total_d == '0);
      occupancy_now_o <= occ_wide[OCC_W-1:0];
      out_urgency_o   <= '0;
      out_tag_o       <= '0;
      out_age_o       <= '0;
      status_o        <= ST_OK;
      if (op_q == OP_DEQ) begin
        if (is_empty) begin
          status_o <= ST_EMPTY;
        end else begin
          out_urgency_o <= URG_W'(sel_q) + URG_W'(1);
          out_tag_o     <= rd_q[DW-1:AGE_W];
          out_age_o     <= rd_q[AGE_W-1:0];
        end
      end else if (is_full) begin
        status_o <= ST_FULL;
      end
    end
  end

endmodule

[sv/spq_checker.sv]
module spq_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [spq_pkg::STS_W-1:0]  status_o,
  input logic [spq_pkg::URG_W-1:0]  out_urgency_o,
  input logic [spq_pkg::TAG_W-1:0]  out_tag_o,
  input logic [spq_pkg::AGE_W-1:0]  out_age_o,
  input logic                       now_empty_o,
  input logic [spq_pkg::OCC_W-1:0]  occupancy_now_o
);
  import spq_pkg::*;

  // A stalled result beat keeps its status, tag, age and occupancy.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(out_tag_o) && $stable(out_age_o) && $stable(occupancy_now_o))
    else $error("result beat changed while stalled");

  // A dequeue on an empty queue leaves it empty.
  a_empty_deq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> now_empty_o && occupancy_now_o == '0)
    else $error("empty dequeue reported a non-empty queue");

  // Error results carry no entry.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |->
      out_urgency_o == '0 && out_tag_o == '0 && out_age_o == '0)
    else $error("error result carries entry data");

  // A returned entry only comes with a good status.
  a_entry_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_urgency_o != '0 |-> status_o == ST_OK)
    else $error("entry returned with an error status");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .out_urgency_o   (out_urgency_o),
  .out_tag_o       (out_tag_o),
  .out_age_o       (out_age_o),
  .now_empty_o     (now_empty_o),
  .occupancy_now_o (occupancy_now_o)
);
